// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared forms for the concurrent checks of the frame builder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/ccfb_pkg.sv =====
// ----------------------------------------------------------------------------
// ccfb_pkg
// types, constants and helpers shared by the command frame builder
// ----------------------------------------------------------------------------
package ccfb_pkg;

	localparam int MAX_PATH    = 32;
	localparam int CNT_W       = $clog2(MAX_PATH + 1);
	localparam int IDX_W       = $clog2(MAX_PATH);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// command codes
	localparam logic [1:0] CMD_PLAIN = 2'd0;
	localparam logic [1:0] CMD_PATH  = 2'd1;
	localparam logic [1:0] CMD_DATA  = 2'd2;

	// job kinds between front and back
	localparam logic [1:0] JOB_HDR  = 2'd0;
	localparam logic [1:0] JOB_DATA = 2'd1;
	localparam logic [1:0] JOB_REJ  = 2'd2;
	localparam logic [1:0] JOB_PATH = 2'd3;

	localparam logic [7:0] SYNC_BYTE  = 8'hAA;
	localparam logic [7:0] CHAR_STAR  = 8'h2A;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_LC_A  = 8'h61;
	localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
	localparam logic [7:0] CASE_DIFF  = 8'h20;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] opcode;
		logic [7:0] payload_length;
		logic [7:0] device;
		logic [7:0] data_byte;
		logic       final_char;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_done;
		logic       reject;
	} res_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       byte_a;  // opcode or data byte
		logic [7:0]       byte_b;  // payload length
		logic [7:0]       device;
		logic [CNT_W-1:0] cnt;
		logic [CNT_W-1:0] slash;
		logic             last;    // data byte closes the frame
	} job_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [7:0]       data;
	} ram_wr_t;

	typedef struct packed {
		logic path_done;  // checksum of a path frame going out
		logic ram_busy;   // back is reading the path store
	} back_stat_t;

	function automatic logic [7:0] upper_of(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
			r = c - CASE_DIFF;
		end
		return r;
	endfunction

endpackage

// ===== rtl/ccfb_ram.sv =====
// ----------------------------------------------------------------------------
// ccfb_ram
// generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module ccfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/ccfb_front.sv =====
// ----------------------------------------------------------------------------
// ccfb_front
// accepts command words, tracks frame mode, collects path characters
// ----------------------------------------------------------------------------
module ccfb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ccfb_pkg::cmd_t      cmd,
	output logic                busy,
	input  logic                full,
	input  logic                path_done,
	output logic                push,
	output ccfb_pkg::job_t      job,
	output ccfb_pkg::ram_wr_t   wr
);

	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_PLAIN = 2'd1;
	localparam logic [1:0] MODE_PATH  = 2'd2;
	localparam logic [1:0] MODE_OVER  = 2'd3;
	localparam int         TW         = ccfb_pkg::CNT_W + 2;

	logic [1:0]                 mode_q, mode_d;
	logic [7:0]                 left_q, left_d;
	logic [ccfb_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic [ccfb_pkg::CNT_W-1:0] slash_q, slash_d;
	logic [7:0]                 op_q, op_d;
	logic [7:0]                 dev_q, dev_d;
	logic                       lock_q, lock_d;
	logic                       accept;
	logic                       extra;
	logic                       ends;
	logic [TW-1:0]              tnew;

	assign busy   = full | lock_q;
	assign accept = start & ~busy;

	// a slash after the first character costs one extra output byte
	assign extra = (cnt_q != '0) && (cmd.data_byte == ccfb_pkg::CHAR_SLASH);
	assign ends  = (cmd.data_byte == ccfb_pkg::CHAR_NUL) || cmd.final_char;
	assign tnew  = TW'(cnt_q) + TW'(slash_q) + TW'(extra) + TW'(1);

	always_comb begin
		mode_d  = mode_q;
		left_d  = left_q;
		cnt_d   = cnt_q;
		slash_d = slash_q;
		op_d    = op_q;
		dev_d   = dev_q;
		lock_d  = lock_q;
		push    = 1'b0;
		job     = '0;
		wr      = '0;
		if (path_done) begin
			lock_d = 1'b0;
		end
		if (accept) begin
			case (cmd.command)
				ccfb_pkg::CMD_PLAIN: begin
					push       = 1'b1;
					job.kind   = ccfb_pkg::JOB_HDR;
					job.byte_a = cmd.opcode;
					job.byte_b = cmd.payload_length;
					left_d     = cmd.payload_length;
					mode_d     = (cmd.payload_length == 8'd0) ? MODE_IDLE : MODE_PLAIN;
				end
				ccfb_pkg::CMD_PATH: begin
					op_d    = cmd.opcode;
					dev_d   = cmd.device;
					cnt_d   = '0;
					slash_d = '0;
					mode_d  = MODE_PATH;
				end
				ccfb_pkg::CMD_DATA: begin
					case (mode_q)
						MODE_PLAIN: begin
							push       = 1'b1;
							job.kind   = ccfb_pkg::JOB_DATA;
							job.byte_a = cmd.data_byte;
							job.last   = (left_q == 8'd1);
							left_d     = left_q - 8'd1;
							if (left_q == 8'd1) begin
								mode_d = MODE_IDLE;
							end
						end
						MODE_PATH, MODE_OVER: begin
							if (cmd.data_byte != ccfb_pkg::CHAR_NUL && mode_q == MODE_PATH) begin
								if (tnew > TW'(ccfb_pkg::MAX_PATH)) begin
									mode_d = MODE_OVER;
								end else begin
									wr.en   = 1'b1;
									wr.addr = cnt_q[ccfb_pkg::IDX_W-1:0];
									wr.data = cmd.data_byte;
									cnt_d   = cnt_q + ccfb_pkg::CNT_W'(1);
									slash_d = slash_q + ccfb_pkg::CNT_W'(extra);
								end
							end
							if (ends) begin
								push = 1'b1;
								if (mode_d == MODE_OVER || cnt_d == '0) begin
									job.kind = ccfb_pkg::JOB_REJ;
								end else begin
									job.kind   = ccfb_pkg::JOB_PATH;
									job.byte_a = op_q;
									job.device = dev_q;
									job.cnt    = cnt_d;
									job.slash  = slash_d;
									lock_d     = 1'b1;
								end
								mode_d = MODE_IDLE;
							end
						end
						default: begin
							push     = 1'b1;
							job.kind = ccfb_pkg::JOB_REJ;
						end
					endcase
				end
				default: begin
					push     = 1'b1;
					job.kind = ccfb_pkg::JOB_REJ;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			left_q  <= '0;
			cnt_q   <= '0;
			slash_q <= '0;
			lock_q  <= 1'b0;
		end else begin
			mode_q  <= mode_d;
			left_q  <= left_d;
			cnt_q   <= cnt_d;
			slash_q <= slash_d;
			lock_q  <= lock_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q  <= op_d;
		dev_q <= dev_d;
	end

endmodule

// ===== rtl/ccfb_queue.sv =====
// ----------------------------------------------------------------------------
// ccfb_queue
// small job queue between the front and the back
// ----------------------------------------------------------------------------
module ccfb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ccfb_pkg::job_t job_in,
	input  logic           pop,
	output logic           valid,
	output logic           full,
	output ccfb_pkg::job_t job_out
);

	ccfb_pkg::job_t                entry_q [ccfb_pkg::QUEUE_DEPTH];
	logic [ccfb_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [ccfb_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [ccfb_pkg::QPTR_W:0]     count_q;
	logic                          do_push;
	logic                          do_pop;

	assign valid   = (count_q != '0);
	assign full    = (count_q == (ccfb_pkg::QPTR_W + 1)'(ccfb_pkg::QUEUE_DEPTH));
	assign job_out = entry_q[rd_ptr_q];
	assign do_push = push & ~full;
	assign do_pop  = pop & valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + ccfb_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + ccfb_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (ccfb_pkg::QPTR_W + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (ccfb_pkg::QPTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= job_in;
		end
	end

endmodule

// ===== rtl/ccfb_back.sv =====
// ----------------------------------------------------------------------------
// ccfb_back
// byte sequencer: takes a queued job in its idle state, then turns it into frame bytes, one per cycle
// ----------------------------------------------------------------------------
module ccfb_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid,
	input  ccfb_pkg::job_t             job,
	output logic                       pop,
	output logic [ccfb_pkg::IDX_W-1:0] rd_addr,
	input  logic [7:0]                 rd_data,
	output ccfb_pkg::back_stat_t       stat,
	output logic                       strobe,
	output ccfb_pkg::res_t             res
);

	localparam logic [3:0] B_IDLE  = 4'd0;
	localparam logic [3:0] B_SYNC  = 4'd1;
	localparam logic [3:0] B_OP    = 4'd2;
	localparam logic [3:0] B_LEN   = 4'd3;
	localparam logic [3:0] B_DEV   = 4'd4;
	localparam logic [3:0] B_CHAR  = 4'd5;
	localparam logic [3:0] B_SLASH = 4'd6;
	localparam logic [3:0] B_DATA  = 4'd7;
	localparam logic [3:0] B_SUM   = 4'd8;
	localparam logic [3:0] B_REJ   = 4'd9;

	logic [3:0]                 state_q, state_d;
	ccfb_pkg::job_t             job_q;
	logic [ccfb_pkg::CNT_W-1:0] idx_q, idx_d;
	logic [7:0]                 sum_q, sum_d;
	logic                       emit;
	ccfb_pkg::res_t             res_d;
	logic                       strobe_q;
	ccfb_pkg::res_t             res_q;

	assign rd_addr = idx_d[ccfb_pkg::IDX_W-1:0];
	assign strobe  = strobe_q;
	assign res     = res_q;

	always_comb begin
		state_d        = state_q;
		idx_d          = idx_q;
		pop            = 1'b0;
		emit           = 1'b0;
		res_d          = '0;
		stat.path_done = 1'b0;
		stat.ram_busy  = (state_q == B_CHAR) || (state_q == B_SLASH);
		case (state_q)
			B_IDLE: begin
				if (valid) begin
					pop = 1'b1;
					case (job.kind)
						ccfb_pkg::JOB_HDR, ccfb_pkg::JOB_PATH: state_d = B_SYNC;
						ccfb_pkg::JOB_DATA:                    state_d = B_DATA;
						default:                               state_d = B_REJ;
					endcase
				end
			end
			B_SYNC: begin
				emit           = 1'b1;
				res_d.out_byte = ccfb_pkg::SYNC_BYTE;
				state_d        = B_OP;
			end
			B_OP: begin
				emit           = 1'b1;
				res_d.out_byte = job_q.byte_a;
				state_d        = B_LEN;
			end
			B_LEN: begin
				emit = 1'b1;
				if (job_q.kind == ccfb_pkg::JOB_PATH) begin
					res_d.out_byte = 8'(job_q.cnt) + 8'(job_q.slash) + 8'd1;
					state_d        = B_DEV;
				end else begin
					res_d.out_byte = job_q.byte_b;
					if (job_q.byte_b == 8'd0) begin
						state_d = B_SUM;
					end else begin
						res_d.run_last = 1'b1;
						state_d        = B_IDLE;
					end
				end
			end
			B_DEV: begin
				emit           = 1'b1;
				res_d.out_byte = job_q.device;
				idx_d          = '0;
				state_d        = B_CHAR;
			end
			B_CHAR: begin
				emit  = 1'b1;
				idx_d = idx_q + ccfb_pkg::CNT_W'(1);
				if (idx_q == '0) begin
					res_d.out_byte = ccfb_pkg::upper_of(rd_data);
				end else if (rd_data == ccfb_pkg::CHAR_DOT || rd_data == ccfb_pkg::CHAR_SLASH) begin
					res_d.out_byte = ccfb_pkg::CHAR_STAR;
				end else begin
					res_d.out_byte = ccfb_pkg::upper_of(rd_data);
				end
				if (idx_q != '0 && rd_data == ccfb_pkg::CHAR_SLASH) begin
					state_d = B_SLASH;
				end else if (idx_d == job_q.cnt) begin
					state_d = B_SUM;
				end
			end
			B_SLASH: begin
				emit           = 1'b1;
				res_d.out_byte = ccfb_pkg::CHAR_SLASH;
				state_d        = (idx_q == job_q.cnt) ? B_SUM : B_CHAR;
			end
			B_DATA: begin
				emit           = 1'b1;
				res_d.out_byte = job_q.byte_a;
				if (job_q.last) begin
					state_d = B_SUM;
				end else begin
					res_d.run_last = 1'b1;
					state_d        = B_IDLE;
				end
			end
			B_SUM: begin
				emit             = 1'b1;
				res_d.out_byte   = sum_q;
				res_d.frame_done = 1'b1;
				res_d.run_last   = 1'b1;
				stat.path_done   = (job_q.kind == ccfb_pkg::JOB_PATH);
				state_d          = B_IDLE;
			end
			B_REJ: begin
				emit           = 1'b1;
				res_d.reject   = 1'b1;
				res_d.run_last = 1'b1;
				state_d        = B_IDLE;
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// running checksum restarts on the sync byte
	always_comb begin
		sum_d = sum_q;
		if (state_q == B_SYNC) begin
			sum_d = ccfb_pkg::SYNC_BYTE;
		end else if (emit && !res_d.frame_done && !res_d.reject) begin
			sum_d = sum_q + res_d.out_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
		end
		idx_q <= idx_d;
		sum_q <= sum_d;
		res_q <= res_d;
	end

endmodule

// ===== rtl/checksummed_command_frame_builder_unit.sv =====
// ----------------------------------------------------------------------------
// checksummed_command_frame_builder_unit
// builds sync/opcode/length/payload/checksum command frames for a serial link
// ----------------------------------------------------------------------------
// A word is taken on a rising edge with start high and busy low. Each frame
// byte appears on res for exactly one cycle with strobe high; the receiver
// cannot hold results off, so it must take every strobed word. A plain begin
// word gives 3 bytes (4 when the payload is empty) and each payload word gives
// 1 byte (2 on the last one, which carries the checksum); these come out one
// per cycle once the back takes the job, which is later while earlier jobs
// wait in the queue. The back takes each job from the queue in its idle
// state and then emits its bytes, so it takes no new job before the last
// byte of the previous one is out. A path begin and the path characters give
// nothing until the path ends; the end word then gives transformed length + 5
// bytes, one per cycle, read from the path store. The front takes one word
// per cycle while the four-entry job queue has room, so busy rises only when
// the queue fills or while a finished path frame is queued or going out,
// since the path store holds one path at a time. Refused words (stray byte,
// undefined command, empty or overlong path) give one reject word with
// out_byte zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module checksummed_command_frame_builder_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ccfb_pkg::cmd_t cmd,
	output logic           busy,
	output logic           strobe,
	output ccfb_pkg::res_t res
);

	// front to queue
	logic                        push;
	ccfb_pkg::job_t              job_in;
	logic                        full;

	// queue to back
	logic                        pop;
	logic                        valid;
	ccfb_pkg::job_t              job_out;

	// path store ports
	ccfb_pkg::ram_wr_t           wr;
	logic [ccfb_pkg::IDX_W-1:0]  rd_addr;
	logic [7:0]                  rd_data;

	// back status, releases the front's path lock
	ccfb_pkg::back_stat_t        stat;

	// front: classify words, keep frame mode, collect path characters
	ccfb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.full      (full),
		.path_done (stat.path_done),
		.push      (push),
		.job       (job_in),
		.wr        (wr)
	);

	// jobs waiting for the back
	ccfb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (job_in),
		.pop     (pop),
		.valid   (valid),
		.full    (full),
		.job_out (job_out)
	);

	// raw path characters, written by the front, read by the back
	ccfb_ram #(
		.WIDTH (8),
		.DEPTH (ccfb_pkg::MAX_PATH)
	) u_path_store (
		.clk     (clk),
		.wr_en   (wr.en),
		.wr_addr (wr.addr),
		.wr_data (wr.data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// back: emit frame bytes and checksum
	ccfb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (valid),
		.job     (job_out),
		.pop     (pop),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.stat    (stat),
		.strobe  (strobe),
		.res     (res)
	);

	// front never pushes a job while the queue has no room for it
	`ASSERT_IMPL(a_no_overflow, clk, arst_n, push, !full)

	// path store is never written while a path frame is being read out
	`ASSERT_IMPL(a_store_quiet, clk, arst_n, stat.ram_busy, !wr.en)

	// a checksum closes the item's results and is never a reject
	`ASSERT_IMPL(a_done_last, clk, arst_n, strobe && res.frame_done, res.run_last && !res.reject)

	// once a path frame finishes, only a full queue can hold the input off
	`ASSERT_NEXT(a_lock_release, clk, arst_n, stat.path_done, busy == full)

endmodule

// ===== sim/ccfb_frame_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ccfb_frame_checker
// predicts the frame bytes of every accepted command word and compares them,
// field by field and in order, with the strobed result words of the builder
// ----------------------------------------------------------------------------
module ccfb_frame_checker
	import ccfb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  cmd_t cmd,
	input  logic strobe,
	input  res_t res,
	output int   fail_count,
	output int   pending,
	output int   word_count,
	output int   result_count,
	output int   frame_count,
	output int   reject_count
);

	typedef enum logic [1:0] {
		FM_IDLE,
		FM_PLAIN,
		FM_PATH,
		FM_OVER
	} frame_mode_e;

	frame_mode_e mode;
	logic [7:0]  path_opcode;
	logic [7:0]  path_device;
	logic [7:0]  plain_left;
	logic [7:0]  frame_sum;
	logic [7:0]  path_chars [MAX_PATH];
	logic [5:0]  char_cnt;
	logic [5:0]  slash_cnt;
	res_t        expected_frame_bytes [$];
	int          errors;
	int          n_words;
	int          n_results;
	int          n_frames;
	int          n_rejects;

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c inside {[CHAR_LC_A:CHAR_LC_Z]}) ? (c ^ CASE_DIFF) : c;
	endfunction

	task automatic push_frame_byte(input logic [7:0] b);
		frame_sum = frame_sum + b;
		expected_frame_bytes.push_back('{out_byte: b, run_last: 1'b0, frame_done: 1'b0,
			reject: 1'b0});
	endtask

	task automatic push_checksum();
		expected_frame_bytes.push_back('{out_byte: frame_sum, run_last: 1'b0,
			frame_done: 1'b1, reject: 1'b0});
	endtask

	task automatic push_refusal();
		expected_frame_bytes.push_back('{out_byte: 8'h00, run_last: 1'b0, frame_done: 1'b0,
			reject: 1'b1});
	endtask

	task automatic emit_path_frame();
		int         i;
		logic [7:0] c;
		frame_sum = 8'h00;
		push_frame_byte(SYNC_BYTE);
		push_frame_byte(path_opcode);
		push_frame_byte(8'(char_cnt + slash_cnt + 1));
		push_frame_byte(path_device);
		// the leading character is only uppercased
		push_frame_byte(to_upper(path_chars[0]));
		for (i = 1; i < int'(char_cnt); i++) begin
			c = path_chars[i];
			if (c == CHAR_DOT) begin
				push_frame_byte(CHAR_STAR);
			end else if (c == CHAR_SLASH) begin
				push_frame_byte(CHAR_STAR);
				push_frame_byte(CHAR_SLASH);
			end else begin
				push_frame_byte(to_upper(c));
			end
		end
		push_checksum();
	endtask

	task automatic path_data(input cmd_t w);
		logic ends;
		logic extra;
		int   grown;
		ends = (w.data_byte == CHAR_NUL) || w.final_char;
		if (w.data_byte != CHAR_NUL && mode == FM_PATH) begin
			extra = (char_cnt != 0) && (w.data_byte == CHAR_SLASH);
			grown = int'(char_cnt) + int'(slash_cnt) + int'(extra) + 1;
			if (grown > MAX_PATH) begin
				mode = FM_OVER;
			end else begin
				path_chars[int'(char_cnt) % MAX_PATH] = w.data_byte;
				char_cnt = char_cnt + 6'd1;
				slash_cnt = slash_cnt + 6'(extra);
			end
		end
		if (ends) begin
			if (mode == FM_OVER || char_cnt == 0) begin
				push_refusal();
			end else begin
				emit_path_frame();
			end
			mode = FM_IDLE;
		end
	endtask

	task automatic predict_frame_bytes(input cmd_t w);
		int   base_size;
		res_t tail;
		base_size = expected_frame_bytes.size();
		case (w.command)
			CMD_PLAIN: begin
				frame_sum = 8'h00;
				push_frame_byte(SYNC_BYTE);
				push_frame_byte(w.opcode);
				push_frame_byte(w.payload_length);
				if (w.payload_length == 8'h00) begin
					push_checksum();
					mode = FM_IDLE;
				end else begin
					plain_left = w.payload_length;
					mode = FM_PLAIN;
				end
			end
			CMD_PATH: begin
				path_opcode = w.opcode;
				path_device = w.device;
				char_cnt = '0;
				slash_cnt = '0;
				mode = FM_PATH;
			end
			CMD_DATA: begin
				if (mode == FM_PLAIN) begin
					push_frame_byte(w.data_byte);
					plain_left = plain_left - 8'd1;
					if (plain_left == 8'h00) begin
						push_checksum();
						mode = FM_IDLE;
					end
				end else if (mode == FM_PATH || mode == FM_OVER) begin
					path_data(w);
				end else begin
					push_refusal();
				end
			end
			default: begin
				push_refusal();
			end
		endcase
		if (expected_frame_bytes.size() > base_size) begin
			tail = expected_frame_bytes.pop_back();
			tail.run_last = 1'b1;
			expected_frame_bytes.push_back(tail);
		end
	endtask

	task automatic compare_result(input res_t got);
		res_t exp_word;
		n_results++;
		if (expected_frame_bytes.size() == 0) begin
			$error("result word with nothing expected: out_byte %02h run_last %0b frame_done %0b reject %0b",
				got.out_byte, got.run_last, got.frame_done, got.reject);
			errors++;
		end else begin
			exp_word = expected_frame_bytes.pop_front();
			if (got.out_byte !== exp_word.out_byte) begin
				$error("out_byte: expected %02h, got %02h", exp_word.out_byte, got.out_byte);
				errors++;
			end
			if (got.run_last !== exp_word.run_last) begin
				$error("run_last: expected %0b, got %0b", exp_word.run_last, got.run_last);
				errors++;
			end
			if (got.frame_done !== exp_word.frame_done) begin
				$error("frame_done: expected %0b, got %0b", exp_word.frame_done, got.frame_done);
				errors++;
			end
			if (got.reject !== exp_word.reject) begin
				$error("reject: expected %0b, got %0b", exp_word.reject, got.reject);
				errors++;
			end
			if (exp_word.frame_done) n_frames++;
			if (exp_word.reject) n_rejects++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = FM_IDLE;
			path_opcode = '0;
			path_device = '0;
			plain_left = '0;
			frame_sum = '0;
			char_cnt = '0;
			slash_cnt = '0;
			expected_frame_bytes.delete();
			errors = 0;
			n_words = 0;
			n_results = 0;
			n_frames = 0;
			n_rejects = 0;
		end else begin
			// results first: a word taken at this edge cannot have produced one yet
			if (strobe) compare_result(res);
			if (start && !busy) begin
				n_words++;
				predict_frame_bytes(cmd);
			end
		end
		fail_count <= errors;
		pending <= expected_frame_bytes.size();
		word_count <= n_words;
		result_count <= n_results;
		frame_count <= n_frames;
		reject_count <= n_rejects;
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the checksummed command frame builder: a directed
// pass over the corner cases, then random plain and path frames mixed with
// stray and broken words, under several sender idling patterns
// ----------------------------------------------------------------------------
module tb_top;
	import ccfb_pkg::*;

	localparam logic [1:0] CMD_UNDEF    = 2'd3;
	localparam int         TOTAL_WORDS  = 170;
	localparam int         STALL_LIMIT  = 1000;
	localparam int         TAIL_CYCLES  = 16;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	cmd_t cmd    = '0;
	logic busy;
	logic strobe;
	res_t res;

	int fail_count;
	int pending;
	int word_count;
	int result_count;
	int frame_count;
	int reject_count;

	int idle_pct;
	int random_sent;
	int quiet_cycles;

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	checksummed_command_frame_builder_unit u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.busy  (busy),
		.strobe(strobe),
		.res   (res)
	);

	ccfb_frame_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.strobe      (strobe),
		.res         (res),
		.fail_count  (fail_count),
		.pending     (pending),
		.word_count  (word_count),
		.result_count(result_count),
		.frame_count (frame_count),
		.reject_count(reject_count)
	);

	// watchdog: a run where neither side moves a word for too long is hung
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("checksummed_command_frame_builder_unit verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end else begin
			quiet_cycles <= 0;
		end
	end

	function automatic cmd_t word_of(input logic [1:0] c, input logic [7:0] op,
		input logic [7:0] plen, input logic [7:0] dev, input logic [7:0] db,
		input logic fin);
		cmd_t w;
		w.command = c;
		w.opcode = op;
		w.payload_length = plen;
		w.device = dev;
		w.data_byte = db;
		w.final_char = fin;
		return w;
	endfunction

	// every field random so unused fields still toggle all their bits
	function automatic cmd_t rand_word(input logic [1:0] c);
		return word_of(c, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)));
	endfunction

	// path characters lean toward letters, dots and slashes; never nul
	function automatic logic [7:0] pick_path_char();
		logic [7:0] c;
		case ($urandom_range(0, 9))
			0, 1, 2: c = 8'($urandom_range(CHAR_LC_A, CHAR_LC_Z));
			3:       c = 8'($urandom_range(CHAR_LC_A - CASE_DIFF, CHAR_LC_Z - CASE_DIFF));
			4:       c = CHAR_DOT;
			5, 6:    c = CHAR_SLASH;
			7:       c = 8'($urandom_range(8'h30, 8'h39));
			default: c = 8'($urandom_range(1, 255));
		endcase
		return c;
	endfunction

	// hold the word until it is taken, then maybe let the sender go quiet;
	// start only drops when a gap follows, so back-to-back words keep it high
	task automatic send_word(input cmd_t w);
		cmd <= w;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		random_sent++;
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
	endtask

	task automatic send_data(input logic [7:0] db, input logic fin);
		cmd_t w;
		w = rand_word(CMD_DATA);
		w.data_byte = db;
		w.final_char = fin;
		send_word(w);
	endtask

	// plain frame: header word then exactly payload_length data words
	task automatic random_plain_frame();
		cmd_t w;
		int   plen;
		int   i;
		plen = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
		w = rand_word(CMD_PLAIN);
		w.payload_length = 8'(plen);
		send_word(w);
		for (i = 0; i < plen; i++) begin
			send_data(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
	endtask

	// path frame: mostly short, now and then long enough to reach or pass the limit
	task automatic random_path_frame();
		int len;
		int i;
		logic nul_end;
		case ($urandom_range(0, 19))
			0:       len = 0;
			1, 2:    len = $urandom_range(26, 40);
			default: len = $urandom_range(1, 10);
		endcase
		nul_end = (len == 0) || ($urandom_range(0, 3) == 0);
		send_word(rand_word(CMD_PATH));
		for (i = 0; i < len; i++) begin
			send_data(pick_path_char(), !nul_end && (i == len - 1));
		end
		// a nul ends the path whatever the final mark says
		if (nul_end) send_data(CHAR_NUL, 1'($urandom_range(0, 1)));
	endtask

	// stray and broken traffic
	task automatic random_noise();
		cmd_t w;
		int   i;
		case ($urandom_range(0, 3))
			0: begin
				send_word(rand_word(CMD_DATA));
			end
			1: begin
				send_word(rand_word(CMD_UNDEF));
			end
			2: begin
				// plain frame cut short; the next begin word abandons it
				w = rand_word(CMD_PLAIN);
				w.payload_length = 8'($urandom_range(3, 20));
				send_word(w);
				for (i = 0; i < 2; i++) send_data(8'($urandom_range(0, 255)), 1'b0);
			end
			default: begin
				// path left open
				send_word(rand_word(CMD_PATH));
				for (i = 0; i < $urandom_range(1, 3); i++) send_data(pick_path_char(), 1'b0);
			end
		endcase
	endtask

	task automatic random_frame();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			random_plain_frame();
		end else if (pick < 85) begin
			random_path_frame();
		end else begin
			random_noise();
		end
	endtask

	initial begin
		int phase;
		int phase_pct [3];
		phase_pct = '{0, 58, 8};
		idle_pct = 0;
		random_sent = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: refusals first while the block is idle
		send_word(word_of(CMD_DATA, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1));
		send_word(word_of(CMD_UNDEF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
		// empty plain payload: header and checksum at once
		send_word(word_of(CMD_PLAIN, 8'hFF, 8'h00, 8'hFF, 8'hFF, 1'b0));
		// two-byte plain frame, final mark on a payload byte is ignored
		send_word(word_of(CMD_PLAIN, 8'h00, 8'h02, 8'h00, 8'h00, 1'b0));
		send_word(word_of(CMD_DATA, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1));
		send_word(word_of(CMD_DATA, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0));
		// path with dot and slash rewriting, ended by the final mark
		send_word(word_of(CMD_PATH, 8'h5A, 8'h00, 8'hFF, 8'h00, 1'b0));
		send_word(word_of(CMD_DATA, 8'h00, 8'h00, 8'h00, CHAR_LC_A, 1'b0));
		send_word(word_of(CMD_DATA, 8'h00, 8'h00, 8'h00, CHAR_DOT, 1'b0));
		send_word(word_of(CMD_DATA, 8'h00, 8'h00, 8'h00, CHAR_LC_A + 8'd1, 1'b0));
		send_word(word_of(CMD_DATA, 8'h00, 8'h00, 8'h00, CHAR_SLASH, 1'b0));
		send_word(word_of(CMD_DATA, 8'h00, 8'h00, 8'h00, CHAR_LC_Z, 1'b1));
		// leading slash is not rewritten; nul with final mark ends the path unstored
		send_word(word_of(CMD_PATH, 8'hA5, 8'h00, 8'h00, 8'h00, 1'b0));
		send_word(word_of(CMD_DATA, 8'h00, 8'h00, 8'h00, CHAR_SLASH, 1'b0));
		send_word(word_of(CMD_DATA, 8'h00, 8'h00, 8'h00, CHAR_DOT, 1'b0));
		send_word(word_of(CMD_DATA, 8'h00, 8'h00, 8'h00, CHAR_NUL, 1'b1));
		// empty path gives a refusal
		send_word(word_of(CMD_PATH, 8'h11, 8'h00, 8'h22, 8'h00, 1'b0));
		send_word(word_of(CMD_DATA, 8'h00, 8'h00, 8'h00, CHAR_NUL, 1'b0));
		// new begin abandons a long plain frame, then a path is abandoned the same way
		send_word(word_of(CMD_PLAIN, 8'h3C, 8'hFF, 8'h00, 8'h00, 1'b0));
		send_word(word_of(CMD_DATA, 8'h00, 8'h00, 8'h00, 8'h5A, 1'b0));
		send_word(word_of(CMD_PATH, 8'hC3, 8'h00, 8'h81, 8'h00, 1'b0));
		send_word(word_of(CMD_DATA, 8'h00, 8'h00, 8'h00, CHAR_LC_Z - 8'd4, 1'b0));
		send_word(word_of(CMD_PLAIN, 8'h7E, 8'h01, 8'h00, 8'h00, 1'b0));
		send_word(word_of(CMD_DATA, 8'h00, 8'h00, 8'h00, 8'h80, 1'b1));

		// random part, one phase per sender idling pattern
		for (phase = 0; phase < 3; phase++) begin
			idle_pct = phase_pct[phase];
			while (random_sent < (phase + 1) * TOTAL_WORDS / 3) random_frame();
		end
		start <= 1'b0;

		// drain every outstanding result, then give stray words time to show up
		while (pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d command words: plain and path frames, stray and undefined words",
			word_count);
		$display("checked %0d result words, %0d closed frames, %0d refusals",
			result_count, frame_count, reject_count);
		if (fail_count == 0 && pending == 0) begin
			$display("checksummed_command_frame_builder_unit verification clean");
		end else begin
			$display("checksummed_command_frame_builder_unit verification failed");
		end
		$finish;
	end

endmodule

// ===== checksummed_command_frame_builder_unit.f =====
+incdir+rtl
rtl/ccfb_pkg.sv
rtl/ccfb_ram.sv
rtl/ccfb_front.sv
rtl/ccfb_queue.sv
rtl/ccfb_back.sv
rtl/checksummed_command_frame_builder_unit.sv
sim/ccfb_frame_checker.sv
sim/tb_top.sv
